[src/eulr_pkg.sv]
// ----------------------------------------------------------------------------
// eulr_pkg
// Shared constants, types and the CORDIC step for the XYZ point rotator.
// ----------------------------------------------------------------------------
package eulr_pkg;

  localparam int TRIG_FRAC_BITS = 16;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int COORD_W        = 32;
  localparam int ANG_W          = 16;

  localparam int CRD_W       = 34;
  localparam int CRD_ONE     = 30;
  localparam int CRD_STEPS   = 24;
  localparam int CRD_PER_STG = 2;
  localparam int CRD_STG     = CRD_STEPS / CRD_PER_STG;
  localparam int CRD_IW      = $clog2(CRD_STEPS);
  localparam int CRD_LAT     = CRD_STG + 2;
  localparam int ROT_LAT     = 2;

  localparam logic signed [CRD_W-1:0] CRD_GAIN = CRD_W'(652032874);

  localparam int ANG_FW         = 18;
  localparam int ANG_UNIT_SHIFT = 17;
  localparam logic signed [ANG_FW-1:0] ANG_HALF    = ANG_FW'(23040);
  localparam logic signed [ANG_FW-1:0] ANG_QUARTER = ANG_FW'(11520);
  localparam logic signed [ANG_FW-1:0] ANG_FULL    = ANG_FW'(46080);

  localparam logic signed [CRD_W-1:0] ATAN_TAB [CRD_STEPS] = '{
    CRD_W'(754974720), CRD_W'(445687602), CRD_W'(235489089), CRD_W'(119537938),
    CRD_W'(60000934),  CRD_W'(30029717),  CRD_W'(15018523),  CRD_W'(7509720),
    CRD_W'(3754917),   CRD_W'(1877466),   CRD_W'(938734),    CRD_W'(469367),
    CRD_W'(234684),    CRD_W'(117342),    CRD_W'(58671),     CRD_W'(29335),
    CRD_W'(14668),     CRD_W'(7334),      CRD_W'(3667),      CRD_W'(1833),
    CRD_W'(917),       CRD_W'(458),       CRD_W'(229),       CRD_W'(115)
  };

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } cordic_t;

  function automatic cordic_t cordic_step(cordic_t s, logic [CRD_IW-1:0] idx);
    cordic_t r;
    logic signed [CRD_W-1:0] dx;
    logic signed [CRD_W-1:0] dy;
    dx = s.y >>> idx;
    dy = s.x >>> idx;
    if (!s.z[CRD_W-1]) begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - ATAN_TAB[idx];
    end else begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + ATAN_TAB[idx];
    end
    return r;
  endfunction

endpackage

[src/euler_xyz_point_rotate.sv]
// path: trig units first, then a rotation about each axis in turn, from input transaction to result
// throughput: one transaction per cycle; the whole pipeline stalls together
// when the result is not taken
// reset: only the stage valid bits are cleared, the pipeline then reads empty
// ----------------------------------------------------------------------------
// euler_xyz_point_rotate
// Rotates a Q16.16 point about X, then Y, then Z by Q9.7 degree angles.
// ----------------------------------------------------------------------------
module euler_xyz_point_rotate (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [eulr_pkg::COORD_W-1:0]   point_x_i,
  input  logic signed [eulr_pkg::COORD_W-1:0]   point_y_i,
  input  logic signed [eulr_pkg::COORD_W-1:0]   point_z_i,
  input  logic signed [eulr_pkg::ANG_W-1:0]     turn_about_x_i,
  input  logic signed [eulr_pkg::ANG_W-1:0]     turn_about_y_i,
  input  logic signed [eulr_pkg::ANG_W-1:0]     turn_about_z_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [eulr_pkg::COORD_W-1:0]   rotated_x_o,
  output logic signed [eulr_pkg::COORD_W-1:0]   rotated_y_o,
  output logic signed [eulr_pkg::COORD_W-1:0]   rotated_z_o
);

  localparam int CL  = eulr_pkg::CRD_LAT;
  localparam int RL  = eulr_pkg::ROT_LAT;
  localparam int LAT = CL + 3 * RL;
  localparam int CW  = eulr_pkg::COORD_W;
  localparam int TW  = eulr_pkg::TRIG_W;

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en      = ~vld_q[LAT-1] | ready_i;
  assign ready_o = en;
  assign valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  // trig units
  logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;

  eulr_cordic u_crd_x (.clk_i, .en_i(en), .ang_i(turn_about_x_i), .sin_o(sx), .cos_o(cx));
  eulr_cordic u_crd_y (.clk_i, .en_i(en), .ang_i(turn_about_y_i), .sin_o(sy), .cos_o(cy));
  eulr_cordic u_crd_z (.clk_i, .en_i(en), .ang_i(turn_about_z_i), .sin_o(sz), .cos_o(cz));

  // delay lines
  logic signed [CW-1:0] px_q [CL];
  logic signed [CW-1:0] py_q [CL];
  logic signed [CW-1:0] pz_q [CL];
  logic signed [TW-1:0] sy_q [RL];
  logic signed [TW-1:0] cy_q [RL];
  logic signed [TW-1:0] sz_q [2*RL];
  logic signed [TW-1:0] cz_q [2*RL];
  logic signed [CW-1:0] xc_q [RL];
  logic signed [CW-1:0] yc_q [RL];
  logic signed [CW-1:0] zc_q [RL];

  logic signed [CW-1:0] y1, z1, z2, x2, x3, y3;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q[0] <= point_x_i;
      py_q[0] <= point_y_i;
      pz_q[0] <= point_z_i;
      for (int i = 1; i < CL; i++) begin
        px_q[i] <= px_q[i-1];
        py_q[i] <= py_q[i-1];
        pz_q[i] <= pz_q[i-1];
      end
      sy_q[0] <= sy;
      cy_q[0] <= cy;
      xc_q[0] <= px_q[CL-1];
      yc_q[0] <= y1;
      zc_q[0] <= z2;
      for (int i = 1; i < RL; i++) begin
        sy_q[i] <= sy_q[i-1];
        cy_q[i] <= cy_q[i-1];
        xc_q[i] <= xc_q[i-1];
        yc_q[i] <= yc_q[i-1];
        zc_q[i] <= zc_q[i-1];
      end
      sz_q[0] <= sz;
      cz_q[0] <= cz;
      for (int i = 1; i < 2*RL; i++) begin
        sz_q[i] <= sz_q[i-1];
        cz_q[i] <= cz_q[i-1];
      end
    end
  end

  // about x
  eulr_rot u_rot_x (
    .clk_i, .en_i(en), .a_i(py_q[CL-1]), .b_i(pz_q[CL-1]),
    .cos_i(cx), .sin_i(sx), .p_o(y1), .q_o(z1)
  );

  // about y
  eulr_rot u_rot_y (
    .clk_i, .en_i(en), .a_i(z1), .b_i(xc_q[RL-1]),
    .cos_i(cy_q[RL-1]), .sin_i(sy_q[RL-1]), .p_o(z2), .q_o(x2)
  );

  // about z
  eulr_rot u_rot_z (
    .clk_i, .en_i(en), .a_i(x2), .b_i(yc_q[RL-1]),
    .cos_i(cz_q[2*RL-1]), .sin_i(sz_q[2*RL-1]), .p_o(x3), .q_o(y3)
  );

  assign rotated_x_o = x3;
  assign rotated_y_o = y3;
  assign rotated_z_o = zc_q[RL-1];

endmodule

[src/eulr_cordic.sv]
// ----------------------------------------------------------------------------
// eulr_cordic
// Pipelined sine/cosine of a Q9.7 degree angle: range fold, CORDIC steps,
// rounding to the trig format.
// ----------------------------------------------------------------------------
module eulr_cordic (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [eulr_pkg::ANG_W-1:0]     ang_i,
  output logic signed [eulr_pkg::TRIG_W-1:0]    sin_o,
  output logic signed [eulr_pkg::TRIG_W-1:0]    cos_o
);

  localparam int RND_SH = eulr_pkg::CRD_ONE - eulr_pkg::TRIG_FRAC_BITS;
  localparam logic signed [eulr_pkg::CRD_W:0] RND_HALF =
    ((eulr_pkg::CRD_W+1)'(1) <<< RND_SH) >>> 1;

  eulr_pkg::cordic_t st_q  [eulr_pkg::CRD_STG+1];
  logic              neg_q [eulr_pkg::CRD_STG+1];

  logic signed [eulr_pkg::ANG_FW-1:0] a_wrap, a_fold;
  logic                               neg_d;
  eulr_pkg::cordic_t                  st0_d;

  // wrap into [-180, 180) then fold into [-90, 90]
  always_comb begin
    a_wrap = eulr_pkg::ANG_FW'(ang_i);
    if (a_wrap >= eulr_pkg::ANG_HALF) begin
      a_wrap = a_wrap - eulr_pkg::ANG_FULL;
    end else if (a_wrap < -eulr_pkg::ANG_HALF) begin
      a_wrap = a_wrap + eulr_pkg::ANG_FULL;
    end
    a_fold = a_wrap;
    neg_d  = 1'b0;
    if (a_wrap > eulr_pkg::ANG_QUARTER) begin
      a_fold = eulr_pkg::ANG_HALF - a_wrap;
      neg_d  = 1'b1;
    end else if (a_wrap < -eulr_pkg::ANG_QUARTER) begin
      a_fold = -eulr_pkg::ANG_HALF - a_wrap;
      neg_d  = 1'b1;
    end
    st0_d.x = eulr_pkg::CRD_GAIN;
    st0_d.y = '0;
    st0_d.z = eulr_pkg::CRD_W'(a_fold) <<< eulr_pkg::ANG_UNIT_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]  <= st0_d;
      neg_q[0] <= neg_d;
    end
  end

  for (genvar g = 0; g < eulr_pkg::CRD_STG; g++) begin : g_stg
    eulr_pkg::cordic_t st_d;

    always_comb begin
      st_d = st_q[g];
      for (int k = 0; k < eulr_pkg::CRD_PER_STG; k++) begin
        st_d = eulr_pkg::cordic_step(st_d,
                 eulr_pkg::CRD_IW'(g * eulr_pkg::CRD_PER_STG + k));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g+1]  <= st_d;
        neg_q[g+1] <= neg_q[g];
      end
    end
  end

  logic signed [eulr_pkg::CRD_W:0] cos_full, sin_full;
  logic signed [eulr_pkg::CRD_W:0] cos_rnd, sin_rnd;

  always_comb begin
    cos_full = (eulr_pkg::CRD_W+1)'(st_q[eulr_pkg::CRD_STG].x);
    if (neg_q[eulr_pkg::CRD_STG]) begin
      cos_full = -cos_full;
    end
    sin_full = (eulr_pkg::CRD_W+1)'(st_q[eulr_pkg::CRD_STG].y);
    cos_rnd  = (cos_full + RND_HALF) >>> RND_SH;
    sin_rnd  = (sin_full + RND_HALF) >>> RND_SH;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= cos_rnd[eulr_pkg::TRIG_W-1:0];
      sin_o <= sin_rnd[eulr_pkg::TRIG_W-1:0];
    end
  end

endmodule

[src/eulr_rot.sv]
// ----------------------------------------------------------------------------
// eulr_rot
// Two-stage plane rotation: p = a*c + b*s, q = b*c - a*s, rounded and
// saturated to Q16.16.
// ----------------------------------------------------------------------------
module eulr_rot (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [eulr_pkg::COORD_W-1:0]   a_i,
  input  logic signed [eulr_pkg::COORD_W-1:0]   b_i,
  input  logic signed [eulr_pkg::TRIG_W-1:0]    cos_i,
  input  logic signed [eulr_pkg::TRIG_W-1:0]    sin_i,
  output logic signed [eulr_pkg::COORD_W-1:0]   p_o,
  output logic signed [eulr_pkg::COORD_W-1:0]   q_o
);

  localparam int PW = eulr_pkg::COORD_W + eulr_pkg::TRIG_W;
  localparam int FB = eulr_pkg::TRIG_FRAC_BITS;
  localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (FB - 1);

  logic signed [PW-1:0] ac_q, bs_q, bc_q, as_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q <= PW'(a_i) * PW'(cos_i);
      bs_q <= PW'(b_i) * PW'(sin_i);
      bc_q <= PW'(b_i) * PW'(cos_i);
      as_q <= PW'(a_i) * PW'(sin_i);
    end
  end

  function automatic logic signed [eulr_pkg::COORD_W-1:0] rnd_sat(
    logic signed [PW:0] v
  );
    logic signed [PW:0] r;
    r = (v + HALF) >>> FB;
    if (&r[PW:eulr_pkg::COORD_W-1] || ~|r[PW:eulr_pkg::COORD_W-1]) begin
      return r[eulr_pkg::COORD_W-1:0];
    end else if (r[PW]) begin
      return {1'b1, {(eulr_pkg::COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(eulr_pkg::COORD_W-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= rnd_sat((PW+1)'(ac_q) + (PW+1)'(bs_q));
      q_o <= rnd_sat((PW+1)'(bc_q) - (PW+1)'(as_q));
    end
  end

endmodule
